// ----- rtl/mcw_pkg.sv -----
// Shared types and codes for the motor command watchdog.
// Holds the request/response word structs, the stage word struct and the code constants.
// No dependencies.
package mcw_pkg;

   // Request opcodes
   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_POS  = 2'd1;
   localparam logic [1:0] OP_VEL  = 2'd2;
   localparam logic [1:0] OP_TRQ  = 2'd3;

   // Control mode codes carried in the response word
   localparam logic [2:0] MODE_STOP = 3'd0;
   localparam logic [2:0] MODE_POS  = 3'd1;
   localparam logic [2:0] MODE_VEL  = 3'd2;
   localparam logic [2:0] MODE_TRQ  = 3'd3;
   localparam logic [2:0] MODE_DAMP = 3'd4;

   // Register indexes
   localparam logic [2:0] CSR_KP_GAIN   = 3'd0;
   localparam logic [2:0] CSR_KD_GAIN   = 3'd1;
   localparam logic [2:0] CSR_MOTOR_ID  = 3'd2;
   localparam logic [2:0] CSR_TIMEOUT   = 3'd3;
   localparam logic [2:0] CSR_GEAR      = 3'd4;
   localparam logic [2:0] CSR_INV_GEAR  = 3'd5;

   // Register reset values
   localparam logic [15:0] KP_GAIN_RST   = 16'd2560;
   localparam logic [15:0] KD_GAIN_RST   = 16'd256;
   localparam logic [3:0]  MOTOR_ID_RST  = 4'd0;
   localparam logic [15:0] TIMEOUT_RST   = 16'd100;
   localparam logic [15:0] GEAR_RST      = 16'd1620;
   localparam logic [15:0] INV_GEAR_RST  = 16'd10353;

   localparam int          AGE_W   = 17;
   localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] q_cmd;
      logic signed [31:0] dq_cmd;
      logic signed [31:0] tau_cmd;
      logic [15:0]        kp_cmd;
      logic [15:0]        kd_cmd;
      logic [3:0]         motor_id_out;
      logic [2:0]         control_mode;
   } rsp_type;

   // Word between mode select and scaling: targets already gated to zero when inactive
   typedef struct packed {
      logic signed [31:0] pos;
      logic signed [31:0] vel;
      logic signed [31:0] trq;
      logic [15:0]        kp;
      logic [15:0]        kd;
      logic [3:0]         motor_id;
      logic [2:0]         mode;
   } sel_type;

endpackage

// ----- rtl/mcw_scale.sv -----
// Gear scaling of the selected targets into a motor command word.
// Three independent signed-by-unsigned multiplies, floor shift, and 32-bit saturation of position and velocity.
// Depends on mcw_pkg.
module mcw_scale
   import mcw_pkg::*;
(
   input  sel_type     sel,
   input  logic [15:0] gear_ratio_q8,
   input  logic [15:0] inv_gear_ratio_q16,
   output rsp_type     cmd
);

   logic signed [48:0] pos_prod;
   logic signed [48:0] vel_prod;
   logic signed [48:0] trq_prod;

   // Clamp the product of a Q16.16 value and a Q8.8 ratio, shifted by 8, to the signed 32-bit range
   function automatic logic [31:0] sat_q8(input logic signed [48:0] p);
      logic [40:0] sh;
      logic [31:0] r;
      sh = p[48:8];
      if (sh[40:31] == {10{1'b0}} || sh[40:31] == {10{1'b1}}) begin
         r = sh[31:0];
      end else if (p[48]) begin
         r = 32'h8000_0000;
      end else begin
         r = 32'h7FFF_FFFF;
      end
      return r;
   endfunction

   assign pos_prod = sel.pos * $signed({1'b0, gear_ratio_q8});
   assign vel_prod = sel.vel * $signed({1'b0, gear_ratio_q8});
   assign trq_prod = sel.trq * $signed({1'b0, inv_gear_ratio_q16});

   // Torque shift by 16 always fits in 32 bits
   always_comb begin
      cmd.q_cmd        = sat_q8(pos_prod);
      cmd.dq_cmd       = sat_q8(vel_prod);
      cmd.tau_cmd      = trq_prod[47:16];
      cmd.kp_cmd       = sel.kp;
      cmd.kd_cmd       = sel.kd;
      cmd.motor_id_out = sel.motor_id;
      cmd.control_mode = sel.mode;
   end

endmodule

// ----- rtl/motor_command_watchdog_mode_select.sv -----
// Motor command watchdog with control mode select: top level.
// Holds targets, ages, stop latch, registers and the two pipeline stages.
// Depends on mcw_pkg and mcw_scale.
//
// Usage:
//   req channel: a word carries an opcode and a Q16.16 value. Position, velocity
//   and torque opcodes store a target, restart its age and clear the stop latch;
//   they give no response. A tick opcode gives one command frame on rsp.
//   rsp channel: one frame per tick, in order.
//   csr port: plain write port, taken whenever csr_wr_en is high; write only
//   while no tick is in flight.
// Order: a tick's mode select is stored in the select register, then its
//   scaled frame in the output register, which drives rsp.
// Throughput: one word per cycle while req_stall is low, any mix of opcodes; set
//   by the two register stages, each holding one word.
// Reset: synchronous, active high. Registers take their defaults, targets clear,
//   ages go to all ones (never received) and the pipeline empties.
// Stall: when rsp_stall holds the output register full, the select stage holds
//   and then req_stall rises; no word is lost or repeated.
module motor_command_watchdog_mode_select
   import mcw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // Configuration registers
   logic [15:0] kp_gain_ff;
   logic [15:0] kd_gain_ff;
   logic [3:0]  motor_id_ff;
   logic [15:0] timeout_ff;
   logic [15:0] gear_ff;
   logic [15:0] inv_gear_ff;

   // Watchdog state
   logic signed [31:0] tgt_pos_ff, tgt_vel_ff, tgt_trq_ff;
   logic [AGE_W-1:0]   age_pos_ff, age_vel_ff, age_trq_ff;
   logic               latch_ff;

   // Pipeline
   logic    sel_valid_ff;
   sel_type sel_ff;
   sel_type sel_in;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type cmd;

   logic out_free;
   logic sel_move;
   logic req_take;
   logic tick_take;
   logic pos_on, vel_on, trq_on;
   logic latch_in;

   // Handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign sel_move  = sel_valid_ff && out_free;
   assign req_stall = sel_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign tick_take = req_take && (req_data.opcode == OP_TICK);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_gain_ff  <= KP_GAIN_RST;
         kd_gain_ff  <= KD_GAIN_RST;
         motor_id_ff <= MOTOR_ID_RST;
         timeout_ff  <= TIMEOUT_RST;
         gear_ff     <= GEAR_RST;
         inv_gear_ff <= INV_GEAR_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_KP_GAIN:  kp_gain_ff  <= csr_wdata;
            CSR_KD_GAIN:  kd_gain_ff  <= csr_wdata;
            CSR_MOTOR_ID: motor_id_ff <= csr_wdata[3:0];
            CSR_TIMEOUT:  timeout_ff  <= csr_wdata;
            CSR_GEAR:     gear_ff     <= csr_wdata;
            CSR_INV_GEAR: inv_gear_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Activity of each target against the timeout
   assign pos_on   = age_pos_ff <= {1'b0, timeout_ff};
   assign vel_on   = age_vel_ff <= {1'b0, timeout_ff};
   assign trq_on   = age_trq_ff <= {1'b0, timeout_ff};
   assign latch_in = latch_ff || (!pos_on && !vel_on && !trq_on);

   // Mode select for a tick; inactive targets gated to zero
   always_comb begin
      sel_in          = '0;
      sel_in.motor_id = motor_id_ff;
      if (latch_in) begin
         sel_in.mode = MODE_STOP;
      end else begin
         sel_in.pos = pos_on ? tgt_pos_ff : 32'sd0;
         sel_in.vel = vel_on ? tgt_vel_ff : 32'sd0;
         sel_in.trq = trq_on ? tgt_trq_ff : 32'sd0;
         priority if (pos_on) begin
            sel_in.mode = MODE_POS;
            sel_in.kp   = kp_gain_ff;
            sel_in.kd   = kd_gain_ff;
         end else if (vel_on) begin
            sel_in.mode = MODE_VEL;
            sel_in.kd   = kd_gain_ff;
         end else if (trq_on) begin
            sel_in.mode = MODE_TRQ;
         end else begin
            sel_in.mode = MODE_DAMP;
            sel_in.kd   = kd_gain_ff;
         end
      end
   end

   // Saturating age step
   function automatic logic [AGE_W-1:0] age_step(input logic [AGE_W-1:0] a);
      return (a == AGE_MAX) ? AGE_MAX : a + 1'b1;
   endfunction

   // Target, age and latch update per accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_pos_ff <= '0;
         tgt_vel_ff <= '0;
         tgt_trq_ff <= '0;
         age_pos_ff <= AGE_MAX;
         age_vel_ff <= AGE_MAX;
         age_trq_ff <= AGE_MAX;
         latch_ff   <= 1'b0;
      end else if (req_take) begin
         unique case (req_data.opcode)
            OP_TICK: begin
               latch_ff   <= latch_in;
               age_pos_ff <= age_step(age_pos_ff);
               age_vel_ff <= age_step(age_vel_ff);
               age_trq_ff <= age_step(age_trq_ff);
            end
            OP_POS: begin
               tgt_pos_ff <= req_data.value;
               age_pos_ff <= '0;
               latch_ff   <= 1'b0;
            end
            OP_VEL: begin
               tgt_vel_ff <= req_data.value;
               age_vel_ff <= '0;
               latch_ff   <= 1'b0;
            end
            OP_TRQ: begin
               tgt_trq_ff <= req_data.value;
               age_trq_ff <= '0;
               latch_ff   <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   // Select stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_valid_ff <= 1'b0;
      end else if (tick_take) begin
         sel_valid_ff <= 1'b1;
      end else if (sel_move) begin
         sel_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_take) begin
         sel_ff <= sel_in;
      end
   end

   mcw_scale u_scale (
      .sel                (sel_ff),
      .gear_ratio_q8      (gear_ff),
      .inv_gear_ratio_q16 (inv_gear_ff),
      .cmd                (cmd)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= sel_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (sel_move) begin
         rsp_ff <= cmd;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
